// ----- rtl/core/bmaf_pkg.sv -----
// ----------------------------------------------------------------------------
// bmaf_pkg: shared constants for the burst moving average filter
// Field widths, stream widths and the fixed sample scaling.
// ----------------------------------------------------------------------------
package bmaf_pkg;

    // width of one converter sample field on the input stream
    localparam int FIELD_W = 10;

    // number of sample fields carried by one input transfer
    localparam int INPUT_FIELDS = 8;

    // input stream tdata width: eight 10-bit samples, already whole bytes
    localparam int S_DATA_W = FIELD_W * INPUT_FIELDS;

    // filtered reading width and its byte-padded stream width
    localparam int OUT_W    = 13;
    localparam int M_DATA_W = 16;

    // each sample is scaled by eight before it joins the ring entry
    localparam int SAMPLE_SHIFT = 3;

endpackage

// ----- rtl/core/block_moving_average_filter.sv -----
// ----------------------------------------------------------------------------
// block_moving_average_filter: moving average over converter sample bursts
// Result path: window update stage, window result stage, product and output registers.
// Throughput: one burst per cycle unless m_tready holds the output; the ring
// is read on transfer and written back as the single running total updates.
// Reset: position, priming and total clear; ring contents are not cleared,
// the first burst after reset stands in for every slot until the ring wraps.
// ----------------------------------------------------------------------------
module block_moving_average_filter
    import bmaf_pkg::*;
#(
    parameter int WINDOW_DEPTH      = 64,
    parameter int SAMPLES_PER_BURST = 8,
    parameter int SAMPLE_BITS       = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // sample_0 [9:0], sample_1 [19:10], ... sample_7 [79:70]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // filtered_reading [12:0], zero padding [15:13]
    output logic [M_DATA_W-1:0] m_tdata
);

    // sample bits that survive the field width
    localparam int USED_BITS = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
    localparam longint ENTRY_MAX =
        longint'(SAMPLES_PER_BURST) * ((longint'(1) << USED_BITS) - 1) * 8;
    localparam int ENTRY_W = $clog2(ENTRY_MAX + 1);
    localparam int TOTAL_W = $clog2(ENTRY_MAX * WINDOW_DEPTH + 1);

    // reciprocal for total / (depth * 8), exact over the whole total range
    localparam longint DIVISOR = longint'(WINDOW_DEPTH) * 8;
    localparam int     SHIFT   = TOTAL_W + $clog2(DIVISOR);
    localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int     PROD_W  = 2 * TOTAL_W + 1;
    localparam logic [TOTAL_W:0] RECIP = RECIP64[TOTAL_W:0];

    logic [ENTRY_W-1:0] entry_sum;
    logic               win_valid;
    logic               win_ready;
    logic [TOTAL_W-1:0] win_total;

    logic               prod_valid_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               prod_adv;
    logic [PROD_W-1:0]  quot_full;

    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // ring entry: sum of the used samples, each scaled by eight
    always_comb
    begin
        logic [FIELD_W-1:0] field;
        entry_sum = '0;
        field     = '0;
        for (int k = 0; k < SAMPLES_PER_BURST; k++)
        begin
            field     = s_tdata[k*FIELD_W +: FIELD_W];
            entry_sum = entry_sum +
                        (ENTRY_W'(field[USED_BITS-1:0]) << SAMPLE_SHIFT);
        end
    end

    // ring memory and running total
    bmaf_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ENTRY_W      (ENTRY_W),
        .TOTAL_W      (TOTAL_W)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_entry  (entry_sum),
        .out_valid (win_valid),
        .out_ready (win_ready),
        .out_total (win_total)
    );

    // handshake chain of the divide and output stages
    assign prod_adv  = prod_valid_reg && (!m_tvalid_reg || m_tready);
    assign win_ready = !prod_valid_reg || prod_adv;

    // reciprocal multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (win_ready)
        begin
            prod_valid_reg <= win_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_valid && win_ready)
        begin
            prod_reg <= PROD_W'(win_total) * PROD_W'(RECIP);
        end
    end

    // quotient is the product's upper part
    assign quot_full = prod_reg >> SHIFT;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (prod_adv)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_adv)
        begin
            m_tdata_reg <= M_DATA_W'(quot_full[OUT_W-1:0]);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/core/bmaf_window.sv -----
// ----------------------------------------------------------------------------
// bmaf_window: ring memory and running total of the moving average
// Registers the outgoing ring entry on transfer, then updates the running
// total and writes the new entry back when the update retires. The first entry
// after reset stands in for every ring slot until the ring has wrapped once.
// ----------------------------------------------------------------------------
module bmaf_window
    import bmaf_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64,
    parameter int ENTRY_W      = 16,
    parameter int TOTAL_W      = 22
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ENTRY_W-1:0] in_entry,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [TOTAL_W-1:0] out_total
);

    localparam int POS_W = $clog2(WINDOW_DEPTH);
    localparam logic [POS_W-1:0]   LAST_POS = POS_W'(WINDOW_DEPTH - 1);
    localparam logic [TOTAL_W-1:0] DEPTH_T  = TOTAL_W'(WINDOW_DEPTH);

    // ring storage, undefined until written
    logic [ENTRY_W-1:0] ring_mem [WINDOW_DEPTH];

    // issue side state
    logic [POS_W-1:0]   pos_reg;
    logic               primed_reg;
    logic               lap_reg;
    logic [ENTRY_W-1:0] prime_reg;

    // update stage
    logic               s1_valid_reg;
    logic [ENTRY_W-1:0] s1_entry_reg;
    logic [POS_W-1:0]   s1_pos_reg;
    logic               s1_first_reg;
    logic               s1_from_mem_reg;
    logic [ENTRY_W-1:0] rdata_reg;

    // running total and result stage
    logic [TOTAL_W-1:0] total_reg;
    logic               out_valid_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    logic               accept;
    logic               s1_adv;
    logic [ENTRY_W-1:0] old_entry;
    logic [TOTAL_W-1:0] total_next;

    // handshake chain
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    // outgoing entry: memory once the ring has wrapped, else the first entry
    assign old_entry = s1_from_mem_reg ? rdata_reg : prime_reg;

    // running total update
    always_comb
    begin
        if (s1_first_reg)
        begin
            total_next = TOTAL_W'(s1_entry_reg) * DEPTH_T;
        end
        else
        begin
            total_next = total_reg - TOTAL_W'(old_entry) + TOTAL_W'(s1_entry_reg);
        end
    end

    // write position, priming and lap tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            primed_reg <= 1'b0;
            lap_reg    <= 1'b0;
        end
        else if (accept)
        begin
            primed_reg <= 1'b1;
            if (pos_reg == LAST_POS)
            begin
                pos_reg <= '0;
                lap_reg <= 1'b1;
            end
            else
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    // first entry after reset, held as the value of unwritten slots
    always_ff @(posedge clk)
    begin
        if (accept && !primed_reg)
        begin
            prime_reg <= in_entry;
        end
    end

    // update stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // update stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_entry_reg    <= in_entry;
            s1_pos_reg      <= pos_reg;
            s1_first_reg    <= !primed_reg;
            s1_from_mem_reg <= lap_reg;
        end
    end

    // ring memory: read on transfer, write back when the update retires
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= ring_mem[pos_reg];
        end
        if (s1_adv)
        begin
            ring_mem[s1_pos_reg] <= s1_entry_reg;
        end
    end

    // running total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (s1_adv)
        begin
            total_reg <= total_next;
        end
    end

    // result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_total_reg <= total_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_total = out_total_reg;

endmodule
